>>> hdl/q2e_pkg.sv
package q2e_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int SAMPLE_BITS  = 16;

   localparam int QW      = 16;
   localparam int PROD_W  = 2 * QW;
   localparam int SUM_W   = PROD_W + 2;
   localparam int S_W     = 32;
   localparam int N_W     = 61;
   localparam int ROOT_W  = 31;
   localparam int VEC_W   = 37;
   localparam int ANG_W   = 35;
   localparam int BIN_W   = 6;
   localparam int ZQ_W    = SAMPLE_BITS + 1;
   localparam int QSHIFT  = 32 - SAMPLE_BITS;

   typedef struct packed {
      logic signed [SUM_W-1:0] ra;
      logic signed [SUM_W-1:0] rb;
      logic signed [SUM_W-1:0] ya;
      logic signed [SUM_W-1:0] yb;
      logic signed [S_W-1:0]   s;
   } side_type;

   function automatic logic signed [ANG_W-1:0] atan_tab(input int i);
      logic [31:0] v;
      case (i)
         0:  v = 32'h20000000;  1:  v = 32'h12E4051D;  2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2E;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
         12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2F9;
         15: v = 32'h0000517C;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
         18: v = 32'h00000A2F;  19: v = 32'h00000517;  20: v = 32'h0000028B;
         21: v = 32'h00000145;  22: v = 32'h000000A2;  23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return signed'({{(ANG_W-32){1'b0}}, v});
   endfunction

endpackage

>>> hdl/quaternion_to_euler_bins.sv
// channel  dir  handshake             payload
// req      in   req_tvalid/tready     tdata: quat_w, quat_x, quat_y, quat_z
// rsp      out  rsp_tvalid/tready     tdata: roll_bin, pitch_bin, yaw_bin
// csr      in   csr_we                csr_wdata: bin_count
//
// one word per cycle while the receiver is not stalling; stages in order:
// products, sums, square, one root bit per stage, fold, one rotation per stage, binning
// the whole pipeline advances together whenever the output register is empty or taken
// synchronous reset clears all valid bits and sets bin_count to 18
module quaternion_to_euler_bins (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // roll_bin, pitch_bin, yaw_bin, zero pad
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata
);
   localparam int VW = q2e_pkg::VEC_W;

   logic en;
   logic [q2e_pkg::BIN_W-1:0] bins_ff;
   logic f_v, s_v, cr_v, cp_v, cy_v, br_v, bp_v, by_v;
   q2e_pkg::side_type f_side, s_side;
   logic [q2e_pkg::N_W-1:0] f_n;
   logic [q2e_pkg::ROOT_W-1:0] root;
   logic signed [q2e_pkg::ANG_W-1:0] ang_r, ang_p, ang_y;
   logic [q2e_pkg::BIN_W-1:0] roll_bin, pitch_bin, yaw_bin;

   assign en         = rsp_tready || !rsp_tvalid;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset)
         bins_ff <= 6'd18;
      else if (csr_we)
         bins_ff <= csr_wdata;
   end

   q2e_front u_front (
      .clock, .reset, .en,
      .v_i    (req_tvalid && req_tready),
      .qw     (signed'(req_tdata[15:0])),
      .qx     (signed'(req_tdata[31:16])),
      .qy     (signed'(req_tdata[47:32])),
      .qz     (signed'(req_tdata[63:48])),
      .v_o    (f_v),
      .side_o (f_side),
      .n_o    (f_n)
   );

   q2e_sqrt u_sqrt (
      .clock, .reset, .en,
      .v_i    (f_v),
      .side_i (f_side),
      .n_i    (f_n),
      .v_o    (s_v),
      .side_o (s_side),
      .root_o (root)
   );

   q2e_cordic u_cordic_roll (
      .clock, .reset, .en, .v_i (s_v),
      .vec_x (VW'(s_side.rb)), .vec_y (VW'(s_side.ra)),
      .v_o (cr_v), .ang (ang_r)
   );

   q2e_cordic u_cordic_pitch (
      .clock, .reset, .en, .v_i (s_v),
      .vec_x (signed'(VW'(root))), .vec_y (VW'(s_side.s)),
      .v_o (cp_v), .ang (ang_p)
   );

   q2e_cordic u_cordic_yaw (
      .clock, .reset, .en, .v_i (s_v),
      .vec_x (VW'(s_side.yb)), .vec_y (VW'(s_side.ya)),
      .v_o (cy_v), .ang (ang_y)
   );

   q2e_bin u_bin_roll (
      .clock, .reset, .en, .v_i (cr_v), .ang (ang_r), .half_span (1'b0),
      .bin_cnt (bins_ff), .v_o (br_v), .bin (roll_bin)
   );

   q2e_bin u_bin_pitch (
      .clock, .reset, .en, .v_i (cp_v), .ang (ang_p), .half_span (1'b1),
      .bin_cnt (bins_ff), .v_o (bp_v), .bin (pitch_bin)
   );

   q2e_bin u_bin_yaw (
      .clock, .reset, .en, .v_i (cy_v), .ang (ang_y), .half_span (1'b0),
      .bin_cnt (bins_ff), .v_o (by_v), .bin (yaw_bin)
   );

   assign rsp_tvalid = br_v && bp_v && by_v;
   assign rsp_tdata  = {6'd0, yaw_bin, pitch_bin, roll_bin};

`ifndef SYNTH
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (br_v == bp_v) && (bp_v == by_v))
      else $error("bin lanes out of step");
   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> roll_bin <= bins_ff)
      else $error("roll bin above bin count");
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pitch_bin <= bins_ff)
      else $error("pitch bin above bin count");
   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> yaw_bin <= bins_ff)
      else $error("yaw bin above bin count");
`endif
endmodule

>>> hdl/q2e_front.sv
module q2e_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              v_i,
   input  logic signed [q2e_pkg::QW-1:0]     qw,
   input  logic signed [q2e_pkg::QW-1:0]     qx,
   input  logic signed [q2e_pkg::QW-1:0]     qy,
   input  logic signed [q2e_pkg::QW-1:0]     qz,
   output logic                              v_o,
   output q2e_pkg::side_type                 side_o,
   output logic [q2e_pkg::N_W-1:0]           n_o
);
   localparam int PW = q2e_pkg::PROD_W;
   localparam int SW = q2e_pkg::SUM_W;

   logic [2:0] v_ff;
   logic signed [PW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, zz_ff, wz_ff, xy_ff, wy_ff, zx_ff;
   q2e_pkg::side_type side1_ff, side1_in, side2_ff;
   logic signed [SW-1:0] s_raw;
   logic signed [2*q2e_pkg::S_W-1:0] sq;
   logic [q2e_pkg::N_W-1:0] n_ff, n_in;

   // stage 1 products
   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= qw * qx;  yz_ff <= qy * qz;  xx_ff <= qx * qx;
         yy_ff <= qy * qy;  zz_ff <= qz * qz;  wz_ff <= qw * qz;
         xy_ff <= qx * qy;  wy_ff <= qw * qy;  zx_ff <= qz * qx;
      end
   end

   // stage 2 sums and pitch clamp
   always_comb begin
      side1_in.ra = (SW'(wx_ff) + SW'(yz_ff)) <<< 1;
      side1_in.rb = (SW'(1) <<< 30) - ((SW'(xx_ff) + SW'(yy_ff)) <<< 1);
      side1_in.ya = (SW'(wz_ff) + SW'(xy_ff)) <<< 1;
      side1_in.yb = (SW'(1) <<< 30) - ((SW'(yy_ff) + SW'(zz_ff)) <<< 1);
      s_raw = (SW'(wy_ff) - SW'(zx_ff)) <<< 1;
      if (s_raw > (SW'(1) <<< 30))
         side1_in.s = q2e_pkg::S_W'(SW'(1) <<< 30);
      else if (s_raw < -(SW'(1) <<< 30))
         side1_in.s = q2e_pkg::S_W'(-(SW'(1) <<< 30));
      else
         side1_in.s = q2e_pkg::S_W'(s_raw);
   end

   always_ff @(posedge clock) begin
      if (en)
         side1_ff <= side1_in;
   end

   // stage 3 square of the pitch argument
   always_comb begin
      sq   = side1_ff.s * side1_ff.s;
      n_in = (q2e_pkg::N_W'(1) << 60) - q2e_pkg::N_W'(sq);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff <= side1_ff;
         n_ff     <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         v_ff <= '0;
      else if (en)
         v_ff <= {v_ff[1:0], v_i};
   end

   assign v_o    = v_ff[2];
   assign side_o = side2_ff;
   assign n_o    = n_ff;
endmodule

>>> hdl/q2e_sqrt.sv
module q2e_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           v_i,
   input  q2e_pkg::side_type              side_i,
   input  logic [q2e_pkg::N_W-1:0]        n_i,
   output logic                           v_o,
   output q2e_pkg::side_type              side_o,
   output logic [q2e_pkg::ROOT_W-1:0]     root_o
);
   localparam int RW = q2e_pkg::ROOT_W;
   localparam int NW = q2e_pkg::N_W;
   localparam int TW = 2 * RW;

   logic                v_ff    [0:RW];
   q2e_pkg::side_type   side_ff [0:RW];
   logic [NW-1:0]       rem_ff  [0:RW];
   logic [RW-1:0]       root_ff [0:RW];

   always_comb begin
      v_ff[0]    = v_i;
      side_ff[0] = side_i;
      rem_ff[0]  = n_i;
      root_ff[0] = '0;
   end

   // one root bit per stage, most significant first
   for (genvar k = 0; k < RW; k++) begin : g_bit
      localparam int B = RW - 1 - k;
      logic [TW-1:0] test;
      logic [NW-1:0] rem_in;
      logic [RW-1:0] root_in;
      always_comb begin
         test = (TW'(root_ff[k]) << (B + 1)) + (TW'(1) << (2 * B));
         if (TW'(rem_ff[k]) >= test) begin
            rem_in  = rem_ff[k] - NW'(test);
            root_in = root_ff[k] | (RW'(1) << B);
         end else begin
            rem_in  = rem_ff[k];
            root_in = root_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (reset)
            v_ff[k+1] <= 1'b0;
         else if (en)
            v_ff[k+1] <= v_ff[k];
      end
   end

   assign v_o    = v_ff[RW];
   assign side_o = side_ff[RW];
   assign root_o = root_ff[RW];
endmodule

>>> hdl/q2e_cordic.sv
module q2e_cordic (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 v_i,
   input  logic signed [q2e_pkg::VEC_W-1:0]     vec_x,
   input  logic signed [q2e_pkg::VEC_W-1:0]     vec_y,
   output logic                                 v_o,
   output logic signed [q2e_pkg::ANG_W-1:0]     ang
);
   localparam int N  = q2e_pkg::CORDIC_STEPS;
   localparam int VW = q2e_pkg::VEC_W;
   localparam int AW = q2e_pkg::ANG_W;

   logic                 v_ff    [0:N];
   logic                 zero_ff [0:N];
   logic signed [VW-1:0] x_ff    [0:N];
   logic signed [VW-1:0] y_ff    [0:N];
   logic signed [AW-1:0] z_ff    [0:N];
   logic signed [VW-1:0] x0_in, y0_in;
   logic signed [AW-1:0] z0_in;

   // quadrant fold into the right half plane
   always_comb begin
      x0_in = vec_x;
      y0_in = vec_y;
      z0_in = '0;
      if (vec_x < 0) begin
         if (vec_y >= 0) begin
            x0_in = vec_y;
            y0_in = -vec_x;
            z0_in = AW'(1) <<< 30;
         end else begin
            x0_in = -vec_y;
            y0_in = vec_x;
            z0_in = -(AW'(1) <<< 30);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= (vec_x == 0) && (vec_y == 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         v_ff[0] <= 1'b0;
      else if (en)
         v_ff[0] <= v_i;
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      logic signed [VW-1:0] x_in, y_in;
      logic signed [AW-1:0] z_in;
      always_comb begin
         if (y_ff[k] >= 0) begin
            x_in = x_ff[k] + (y_ff[k] >>> k);
            y_in = y_ff[k] - (x_ff[k] >>> k);
            z_in = z_ff[k] + q2e_pkg::atan_tab(k);
         end else begin
            x_in = x_ff[k] - (y_ff[k] >>> k);
            y_in = y_ff[k] + (x_ff[k] >>> k);
            z_in = z_ff[k] - q2e_pkg::atan_tab(k);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k+1]    <= x_in;
            y_ff[k+1]    <= y_in;
            z_ff[k+1]    <= z_in;
            zero_ff[k+1] <= zero_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (reset)
            v_ff[k+1] <= 1'b0;
         else if (en)
            v_ff[k+1] <= v_ff[k];
      end
   end

   assign v_o = v_ff[N];
   assign ang = zero_ff[N] ? '0 : z_ff[N];
endmodule

>>> hdl/q2e_bin.sv
module q2e_bin (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 v_i,
   input  logic signed [q2e_pkg::ANG_W-1:0]     ang,
   input  logic                                 half_span,
   input  logic [q2e_pkg::BIN_W-1:0]            bin_cnt,
   output logic                                 v_o,
   output logic [q2e_pkg::BIN_W-1:0]            bin
);
   localparam int AW = q2e_pkg::ANG_W;
   localparam int ZW = q2e_pkg::ZQ_W;
   localparam int PW = ZW + q2e_pkg::BIN_W;

   logic [1:0] v_ff;
   logic signed [AW-1:0] lim, zc;
   logic [AW-1:0] off;
   logic [ZW-1:0] zq_ff, zq_in;
   logic          half_ff;
   logic [PW-1:0] prod;
   logic [q2e_pkg::BIN_W-1:0] bin_ff, bin_in;

   always_comb begin
      lim = half_span ? (AW'(1) <<< 30) : (AW'(1) <<< 31);
      if (ang > lim)
         zc = lim;
      else if (ang < -lim)
         zc = -lim;
      else
         zc = ang;
      off   = AW'(zc + lim);
      zq_in = ZW'(off >> q2e_pkg::QSHIFT);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zq_ff   <= zq_in;
         half_ff <= half_span;
      end
   end

   always_comb begin
      prod = PW'(zq_ff) * PW'(bin_cnt);
      if (half_ff)
         bin_in = q2e_pkg::BIN_W'(prod >> (q2e_pkg::SAMPLE_BITS - 1));
      else
         bin_in = q2e_pkg::BIN_W'(prod >> q2e_pkg::SAMPLE_BITS);
   end

   always_ff @(posedge clock) begin
      if (en)
         bin_ff <= bin_in;
   end

   always_ff @(posedge clock) begin
      if (reset)
         v_ff <= '0;
      else if (en)
         v_ff <= {v_ff[0], v_i};
   end

   assign v_o = v_ff[1];
   assign bin = bin_ff;
endmodule

>>> test/quaternion_to_euler_bins_test.sv
`timescale 1ns / 1ps

class euler_scoreboard;
   typedef struct {
      bit [5:0] roll;
      bit [5:0] pitch;
      bit [5:0] yaw;
   } bins_type;

   bins_type pending[$];
   bit [5:0] bin_cnt = 18;
   int errors = 0;

   static const longint arc_turns[16] = '{
      64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C};

   function longint root_floor(bit [63:0] n);
      bit [63:0] res, one;
      res = 0;
      one = 64'h1 << 62;
      while (one > n) one = one >> 2;
      while (one != 0) begin
         if (n >= res + one) begin
            n = n - (res + one);
            res = (res >> 1) + one;
         end else begin
            res = res >> 1;
         end
         one = one >> 2;
      end
      return longint'(res);
   endfunction

   function longint turn_angle(longint y, longint x);
      longint z, t, nx, ny;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = y; y = -x; x = t; z = 64'sd1 << 30;
         end else begin
            t = -y; y = x; x = t; z = -(64'sd1 << 30);
         end
      end
      for (int i = 0; i < 16; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += arc_turns[i];
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= arc_turns[i];
         end
         x = nx;
         y = ny;
      end
      return z;
   endfunction

   function bit [5:0] quantize(longint z, int span_log);
      longint limit;
      bit [63:0] zq;
      limit = 64'sd1 << (span_log - 1);
      if (z > limit) z = limit;
      if (z < -limit) z = -limit;
      zq = 64'(z + limit) >> 16;
      zq = zq * bin_cnt;
      return 6'((zq >> (span_log - 16)) & 63);
   endfunction

   function void note(bit [63:0] word);
      longint w, x, y, z, ra, rb, ya, yb, s, c;
      bins_type e;
      w = longint'($signed(word[15:0]));
      x = longint'($signed(word[31:16]));
      y = longint'($signed(word[47:32]));
      z = longint'($signed(word[63:48]));
      ra = 2 * (w * x + y * z);
      rb = (64'sd1 << 30) - 2 * (x * x + y * y);
      ya = 2 * (w * z + x * y);
      yb = (64'sd1 << 30) - 2 * (y * y + z * z);
      s = 2 * (w * y - z * x);
      if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
      if (s < -(64'sd1 << 30)) s = -(64'sd1 << 30);
      c = root_floor(64'((64'sd1 << 60) - s * s));
      e.roll = quantize(turn_angle(ra, rb), 32);
      e.pitch = quantize(turn_angle(s, c), 31);
      e.yaw = quantize(turn_angle(ya, yb), 32);
      pending.push_back(e);
   endfunction

   function void check(bit [23:0] word);
      bins_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected word %h", $time, word);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (word[5:0] != e.roll) begin
         $display("%0t: roll expected %0d actual %0d", $time, e.roll, word[5:0]);
         errors++;
      end
      if (word[11:6] != e.pitch) begin
         $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, word[11:6]);
         errors++;
      end
      if (word[17:12] != e.yaw) begin
         $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, word[17:12]);
         errors++;
      end
   endfunction
endclass

module quaternion_to_euler_bins_test;
   localparam int DRAIN = 60;
   localparam int LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // quat_w, quat_x, quat_y, quat_z
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;        // roll_bin, pitch_bin, yaw_bin, zero pad
   logic        csr_we = 0;
   logic [5:0]  csr_wdata = '0;

   euler_scoreboard board = new();
   int cycles = 0;
   int stall_mode = 0;
   int burst_left = 0;

   quaternion_to_euler_bins dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_tvalid && req_tready) board.note(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check(rsp_tdata);
      if (cycles > LIMIT) begin
         $display("FAIL quaternion_to_euler_bins");
         $finish;
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ((cycles % 16) < 4);
      endcase
   end

   task automatic send_word(bit [63:0] word);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 20);
      end
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= word;
      burst_left--;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic quat(int w, int x, int y, int z);
      send_word({16'(z), 16'(y), 16'(x), 16'(w)});
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 0;
      burst_left = 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic set_bins(bit [5:0] value);
      settle();
      csr_we <= 1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 0;
      board.bin_cnt = value;
   endtask

   task automatic random_items(int n);
      bit [15:0] c[4];
      int sh;
      repeat (n) begin
         sh = $urandom_range(0, 3);
         foreach (c[i]) begin
            c[i] = 16'($urandom);
            if (sh != 0) c[i] = 16'($signed(c[i]) >>> sh);
         end
         quat(int'($signed(c[0])), int'($signed(c[1])), int'($signed(c[2])),
              int'($signed(c[3])));
      end
   endtask

   task automatic directed_items();
      quat(32767, 0, 0, 0);
      quat(0, 0, 0, 0);
      quat(-32768, -32768, -32768, -32768);
      quat(32767, 32767, 32767, 32767);
      quat(0, 16384, 16384, 0);
      quat(0, 0, 16384, 16384);
      quat(0, 32767, 0, 0);
      quat(0, 0, 0, 32767);
      quat(-32768, 0, -32768, 0);
      quat(32767, 0, -32768, 0);
      quat(23170, 0, 23170, 0);
      quat(23170, 0, -23170, 0);
      quat(23170, 23170, 0, 0);
      quat(23170, 0, 0, -23170);
      quat(-1, -1, -1, -1);
      quat(1, -32768, 1, 32767);
      quat(0, -32768, 0, 0);
      quat(16384, 16384, 16384, 16384);
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 0;
      directed_items();
      random_items(150);
      set_bins(63);
      directed_items();
      random_items(150);
      set_bins(1);
      directed_items();
      random_items(120);
      set_bins(0);
      random_items(60);
      set_bins(6'($urandom_range(2, 62)));
      random_items(150);
      set_bins(18);
      random_items(150);
      settle();
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASS quaternion_to_euler_bins");
      end else begin
         $display("FAIL quaternion_to_euler_bins");
      end
      $finish;
   end
endmodule
